/* sv/bphd_pkg.sv */
// bphd_pkg: shared types and constants for the button press/hold/double detector
// no dependencies

package bphd_pkg;

  localparam int NUM_BUTTONS_DEF = 8;
  localparam int TICK_BITS_DEF   = 24;
  localparam int MAX_LANES       = 8;

  localparam int BUTTONS_W = 8;
  localparam int FRAME_W   = 16;
  localparam int HELD_W    = 24;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] LIFETIME_RESET = 24'd500000;
  localparam logic [CFG_W-1:0] WINDOW_RESET   = 24'd200000;

  localparam logic [CFG_IDX_W-1:0] REG_LIFETIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 1'b1;

  typedef enum logic [1:0] {
    KIND_HOLD    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_PRESS   = 2'd2,
    KIND_DOUBLE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PREV_NONE,
    PREV_HOLD,
    PREV_RELEASE,
    PREV_PRESS
  } prev_t;

  typedef struct packed {
    logic  ev;
    logic  dbl;
    kind_t kind;
  } lane_flags_t;

endpackage

/* sv/button_press_hold_double_detector.sv */
// button_press_hold_double_detector: top level with button lanes, recent-event buffer
// and configuration registers; depends on bphd_pkg, bphd_lane and bphd_merge
//
// Usage
//   in_*  : one transaction per frame; in_tdata holds buttons_down and frame_ticks.
//   out_* : one transaction per event, in ascending button order; a double press
//           follows the press of the same button; out_tlast marks the frame's last.
//   cfg_* : register writes (0 buffer lifetime, 1 double-press window), idle only.
//   All button lanes evaluate a frame in the cycle it is accepted, updating their
//   held time and last kind and the recent-event buffer at once.
//   The frame's events pass through the frame register and then the output register.
//   Throughput: one event per cycle while out_tready is high, set by the single
//   output register; the next frame is accepted in the cycle the previous
//   frame's final event moves to the output register, so frames stream
//   without gaps. A frame with no events produces no transaction.
//   Reset clears all button history, empties the buffer and restores both
//   registers to their defaults. When the receiver stalls, the output register
//   holds its event, one frame waits in the frame register and in_tready drops.

module button_press_hold_double_detector #(
  parameter int NUM_BUTTONS = bphd_pkg::NUM_BUTTONS_DEF,
  parameter int TICK_BITS   = bphd_pkg::TICK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // buttons_down[7:0], frame_ticks[23:8]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // button_index[2:0], held_ticks[26:3]
  output logic [1:0]                      out_tuser,  // event_kind[1:0]
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [bphd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bphd_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int LANES = (NUM_BUTTONS < bphd_pkg::MAX_LANES) ? NUM_BUTTONS
                                                             : bphd_pkg::MAX_LANES;

  logic [bphd_pkg::BUTTONS_W-1:0]  buttons_down;
  logic [bphd_pkg::FRAME_W-1:0]    frame_ticks;
  logic                            accept;

  logic [bphd_pkg::CFG_W-1:0]      lifetime_r, window_r;
  logic                            buf_nonempty_r, buf_nonempty_nxt;
  logic [bphd_pkg::IDX_W-1:0]      buf_button_r, buf_button_nxt;
  bphd_pkg::kind_t                 buf_kind_r, buf_kind_nxt;
  logic [bphd_pkg::CFG_W-1:0]      time_left_r, time_left_nxt;

  logic signed [bphd_pkg::CFG_W+1:0] elapsed;
  logic                              in_window;

  bphd_pkg::lane_flags_t   lane_flags [LANES];
  logic [TICK_BITS-1:0]    lane_held  [LANES];
  logic [LANES-1:0]        rel_ok;

  logic                          any_ev;
  logic [bphd_pkg::IDX_W-1:0]    last_button;
  bphd_pkg::kind_t               last_kind;

  logic                          m_valid, m_last;
  logic [bphd_pkg::IDX_W-1:0]    m_button;
  bphd_pkg::kind_t               m_kind;
  logic [bphd_pkg::HELD_W-1:0]   m_held;

  assign buttons_down = in_tdata[7:0];
  assign frame_ticks  = in_tdata[23:8];
  assign accept       = in_tvalid && in_tready;

  assign elapsed   = $signed({2'b00, lifetime_r}) - $signed({2'b00, time_left_r});
  assign in_window = elapsed < $signed({2'b00, window_r});

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    assign rel_ok[g] = buf_nonempty_r && (buf_button_r == bphd_pkg::IDX_W'(g))
                       && (buf_kind_r == bphd_pkg::KIND_RELEASE) && in_window;

    bphd_lane #(
      .TICK_BITS (TICK_BITS)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .upd     (accept),
      .is_down (buttons_down[g]),
      .dt      (frame_ticks),
      .rel_ok  (rel_ok[g]),
      .flags   (lane_flags[g]),
      .held    (lane_held[g])
    );
  end

  always_comb begin
    any_ev      = 1'b0;
    last_button = '0;
    last_kind   = bphd_pkg::KIND_HOLD;
    for (int i = 0; i < LANES; i++) begin
      if (lane_flags[i].ev) begin
        any_ev      = 1'b1;
        last_button = bphd_pkg::IDX_W'(i);
        last_kind   = lane_flags[i].dbl ? bphd_pkg::KIND_DOUBLE : lane_flags[i].kind;
      end
    end
  end

  always_comb begin
    buf_nonempty_nxt = buf_nonempty_r;
    buf_button_nxt   = buf_button_r;
    buf_kind_nxt     = buf_kind_r;
    if (bphd_pkg::CFG_W'(frame_ticks) > time_left_r) begin
      buf_nonempty_nxt = 1'b0;
      time_left_nxt    = lifetime_r;
    end else begin
      time_left_nxt    = time_left_r - bphd_pkg::CFG_W'(frame_ticks);
    end
    if (any_ev) begin
      buf_nonempty_nxt = 1'b1;
      time_left_nxt    = lifetime_r;
      buf_button_nxt   = last_button;
      buf_kind_nxt     = last_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_nonempty_r <= 1'b0;
      buf_button_r   <= '0;
      buf_kind_r     <= bphd_pkg::KIND_HOLD;
      time_left_r    <= bphd_pkg::LIFETIME_RESET;
    end else if (accept) begin
      buf_nonempty_r <= buf_nonempty_nxt;
      buf_button_r   <= buf_button_nxt;
      buf_kind_r     <= buf_kind_nxt;
      time_left_r    <= time_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= bphd_pkg::LIFETIME_RESET;
      window_r   <= bphd_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bphd_pkg::REG_LIFETIME: lifetime_r <= cfg_wdata;
        bphd_pkg::REG_WINDOW:   window_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bphd_merge #(
    .LANES     (LANES),
    .TICK_BITS (TICK_BITS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept),
    .lane_flags  (lane_flags),
    .lane_held   (lane_held),
    .frame_ready (in_tready),
    .out_valid   (m_valid),
    .out_ready   (out_tready),
    .out_button  (m_button),
    .out_kind    (m_kind),
    .out_held    (m_held),
    .out_last    (m_last)
  );

  assign out_tvalid = m_valid;
  assign out_tdata  = {5'b0, m_held, m_button};
  assign out_tuser  = m_kind;
  assign out_tlast  = m_last;

endmodule

/* sv/bphd_lane.sv */
// bphd_lane: per-button core holding last event kind and held time
// depends on bphd_pkg

module bphd_lane #(
  parameter int TICK_BITS = bphd_pkg::TICK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic                          is_down,
  input  logic [bphd_pkg::FRAME_W-1:0]  dt,
  input  logic                          rel_ok,
  output bphd_pkg::lane_flags_t         flags,
  output logic [TICK_BITS-1:0]          held
);

  localparam int SUM_W = ((TICK_BITS > bphd_pkg::FRAME_W) ? TICK_BITS : bphd_pkg::FRAME_W) + 1;
  localparam logic [SUM_W-1:0] SAT_MAX = {{(SUM_W-TICK_BITS){1'b0}}, {TICK_BITS{1'b1}}};

  bphd_pkg::prev_t       prev_r, prev_nxt;
  logic [TICK_BITS-1:0]  held_r, held_nxt;
  logic                  down_prev;
  logic [TICK_BITS-1:0]  base;
  logic [SUM_W-1:0]      sum;

  always_comb begin
    down_prev = (prev_r == bphd_pkg::PREV_HOLD) || (prev_r == bphd_pkg::PREV_PRESS);
    base      = (prev_r == bphd_pkg::PREV_NONE) ? '0 : held_r;
    sum       = SUM_W'(base) + SUM_W'(dt);
    held      = (sum > SAT_MAX) ? {TICK_BITS{1'b1}} : sum[TICK_BITS-1:0];

    flags.ev   = is_down || down_prev;
    flags.kind = down_prev ? (is_down ? bphd_pkg::KIND_HOLD : bphd_pkg::KIND_RELEASE)
                           : bphd_pkg::KIND_PRESS;
    flags.dbl  = is_down && !down_prev && rel_ok;
  end

  always_comb begin
    prev_nxt = bphd_pkg::PREV_NONE;
    if (flags.ev) begin
      unique case (flags.kind)
        bphd_pkg::KIND_HOLD:    prev_nxt = bphd_pkg::PREV_HOLD;
        bphd_pkg::KIND_RELEASE: prev_nxt = bphd_pkg::PREV_RELEASE;
        bphd_pkg::KIND_PRESS:   prev_nxt = bphd_pkg::PREV_PRESS;
        default:                prev_nxt = bphd_pkg::PREV_NONE;
      endcase
    end
    held_nxt = flags.ev ? held : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= bphd_pkg::PREV_NONE;
    end else if (upd) begin
      prev_r <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      held_r <= held_nxt;
    end
  end

endmodule

/* sv/bphd_merge.sv */
// bphd_merge: frame register gathering lane events and serialising them in button order
// depends on bphd_pkg

module bphd_merge #(
  parameter int LANES     = bphd_pkg::MAX_LANES,
  parameter int TICK_BITS = bphd_pkg::TICK_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  bphd_pkg::lane_flags_t          lane_flags [LANES],
  input  logic [TICK_BITS-1:0]           lane_held  [LANES],
  output logic                           frame_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bphd_pkg::IDX_W-1:0]     out_button,
  output bphd_pkg::kind_t                out_kind,
  output logic [bphd_pkg::HELD_W-1:0]    out_held,
  output logic                           out_last
);

  localparam int SLOTS  = 2 * LANES;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic [SLOTS-1:0]        mask_r, mask_in, first_oh, rem;
  bphd_pkg::kind_t         kind_r [LANES];
  logic [TICK_BITS-1:0]    held_r [LANES];
  logic [LANE_W-1:0]       lane_sel;
  logic                    dbl_sel;
  logic                    load_o;
  logic [TICK_BITS+23:0]   held_ext;

  logic                          out_valid_r;
  logic [bphd_pkg::IDX_W-1:0]    out_button_r;
  bphd_pkg::kind_t               out_kind_r;
  logic [bphd_pkg::HELD_W-1:0]   out_held_r;
  logic                          out_last_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mask_in[2*i]   = lane_flags[i].ev;
      mask_in[2*i+1] = lane_flags[i].dbl;
    end
  end

  // lowest pending slot
  always_comb begin
    lane_sel = '0;
    dbl_sel  = 1'b0;
    first_oh = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        lane_sel    = LANE_W'(i / 2);
        dbl_sel     = 1'((i % 2));
        first_oh    = '0;
        first_oh[i] = 1'b1;
      end
    end
    rem      = mask_r & ~first_oh;
    held_ext = (TICK_BITS+24)'(held_r[lane_sel]);
  end

  assign load_o      = !out_valid_r || out_ready;
  assign frame_ready = (mask_r == '0) || (load_o && (rem == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (load && (mask_in != '0)) begin
      mask_r <= mask_in;
    end else if (load_o && (mask_r != '0)) begin
      mask_r <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < LANES; i++) begin
        kind_r[i] <= lane_flags[i].kind;
        held_r[i] <= lane_held[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_o) begin
      out_valid_r <= (mask_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (load_o && (mask_r != '0)) begin
      out_button_r <= bphd_pkg::IDX_W'(lane_sel);
      out_kind_r   <= dbl_sel ? bphd_pkg::KIND_DOUBLE : kind_r[lane_sel];
      out_held_r   <= held_ext[bphd_pkg::HELD_W-1:0];
      out_last_r   <= (rem == '0);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_button = out_button_r;
  assign out_kind   = out_kind_r;
  assign out_held   = out_held_r;
  assign out_last   = out_last_r;

  a_more_after_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> mask_r != '0)
    else $error("non-final event shown with no events left in frame register");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ((mask_r & (mask_r - 1'b1)) != '0) |-> !frame_ready)
    else $error("frame register accepting while several events remain");

  a_frame_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    load && (mask_in != '0) |=> mask_r != '0)
    else $error("frame with events not captured");

endmodule

/* sim/tb_button_press_hold_double_detector.sv */
// tb_button_press_hold_double_detector: self-checking testbench for the button detector
// predicts every event of each accepted frame and checks the event stream in order
// depends on bphd_pkg and button_press_hold_double_detector

module tb_button_press_hold_double_detector;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [bphd_pkg::IDX_W-1:0]  button;
    bphd_pkg::kind_t             kind;
    logic [bphd_pkg::HELD_W-1:0] held;
    logic                        last;
  } button_event_t;

  class press_tracker;
    bphd_pkg::prev_t             last_kind [bphd_pkg::MAX_LANES];
    logic [bphd_pkg::HELD_W-1:0] held [bphd_pkg::MAX_LANES];
    bit                          buf_full;
    logic [bphd_pkg::IDX_W-1:0]  buf_button;
    bphd_pkg::kind_t             buf_kind;
    logic [bphd_pkg::CFG_W:0]    time_left;
    logic [bphd_pkg::CFG_W-1:0]  lifetime;
    logic [bphd_pkg::CFG_W-1:0]  window;
    button_event_t               pending [$];
    int                          errors;
    int                          frames;
    int                          events;
    int                          doubles;
    int                          saturated;

    function new();
      foreach (last_kind[i]) begin
        last_kind[i] = bphd_pkg::PREV_NONE;
        held[i] = '0;
      end
      buf_full = 1'b0;
      buf_button = '0;
      buf_kind = bphd_pkg::KIND_HOLD;
      lifetime = bphd_pkg::LIFETIME_RESET;
      window = bphd_pkg::WINDOW_RESET;
      time_left = {1'b0, bphd_pkg::LIFETIME_RESET};
      errors = 0;
      frames = 0;
      events = 0;
      doubles = 0;
      saturated = 0;
    endfunction

    function void set_reg(logic [bphd_pkg::CFG_IDX_W-1:0] idx,
                          logic [bphd_pkg::CFG_W-1:0] val);
      if (idx == bphd_pkg::REG_LIFETIME) begin
        lifetime = val;
      end else if (idx == bphd_pkg::REG_WINDOW) begin
        window = val;
      end
    endfunction

    function void push(int b, bphd_pkg::kind_t k, logic [bphd_pkg::HELD_W-1:0] h);
      button_event_t e;
      e.button = bphd_pkg::IDX_W'(b);
      e.kind = k;
      e.held = h;
      e.last = 1'b0;
      pending.insert(pending.size(), e);
      events++;
    endfunction

    function void note_frame(logic [bphd_pkg::BUTTONS_W-1:0] down,
                             logic [bphd_pkg::FRAME_W-1:0] ticks);
      int                          elapsed;
      int                          n;
      bit                          in_window;
      bit                          down_prev;
      bit                          rel_before;
      logic [bphd_pkg::HELD_W:0]   sum;
      logic [bphd_pkg::HELD_W-1:0] h;
      elapsed = int'(lifetime) - int'(time_left);
      in_window = elapsed < int'(window);
      n = 0;
      frames++;
      for (int i = 0; i < bphd_pkg::BUTTONS_W; i++) begin
        down_prev = (last_kind[i] == bphd_pkg::PREV_HOLD)
                    || (last_kind[i] == bphd_pkg::PREV_PRESS);
        sum = {1'b0, (last_kind[i] == bphd_pkg::PREV_NONE) ? {bphd_pkg::HELD_W{1'b0}}
                                                           : held[i]}
              + (bphd_pkg::HELD_W+1)'(ticks);
        h = sum[bphd_pkg::HELD_W] ? {bphd_pkg::HELD_W{1'b1}} : sum[bphd_pkg::HELD_W-1:0];
        rel_before = buf_full && (buf_button == bphd_pkg::IDX_W'(i))
                     && (buf_kind == bphd_pkg::KIND_RELEASE);
        if (down[i]) begin
          push(i, down_prev ? bphd_pkg::KIND_HOLD : bphd_pkg::KIND_PRESS, h);
          n++;
          last_kind[i] = down_prev ? bphd_pkg::PREV_HOLD : bphd_pkg::PREV_PRESS;
          held[i] = h;
          if (!down_prev && rel_before && in_window) begin
            push(i, bphd_pkg::KIND_DOUBLE, h);
            n++;
            doubles++;
          end
        end else if (down_prev) begin
          push(i, bphd_pkg::KIND_RELEASE, h);
          n++;
          last_kind[i] = bphd_pkg::PREV_RELEASE;
          held[i] = h;
        end else begin
          last_kind[i] = bphd_pkg::PREV_NONE;
          held[i] = '0;
        end
        if ((down[i] || down_prev) && h == {bphd_pkg::HELD_W{1'b1}}) begin
          saturated++;
        end
      end
      // buffer ageing, then refresh on any event
      if ((bphd_pkg::CFG_W+1)'(ticks) > time_left) begin
        buf_full = 1'b0;
        time_left = {1'b0, lifetime};
      end else begin
        time_left = time_left - (bphd_pkg::CFG_W+1)'(ticks);
      end
      if (n > 0) begin
        time_left = {1'b0, lifetime};
        buf_full = 1'b1;
        buf_button = pending[pending.size()-1].button;
        buf_kind = pending[pending.size()-1].kind;
        pending[pending.size()-1].last = 1'b1;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_event(logic [bphd_pkg::IDX_W-1:0] b, logic [1:0] k,
                     logic [bphd_pkg::HELD_W-1:0] h, logic last);
      button_event_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected event button %0d kind %0d held %0d", b, k, h));
        return;
      end
      e = pending.pop_front();
      if (b !== e.button) begin
        report($sformatf("button index got %0d want %0d", b, e.button));
      end
      if (k !== e.kind) begin
        report($sformatf("button %0d event kind got %0d want %0d", e.button, k, e.kind));
      end
      if (h !== e.held) begin
        report($sformatf("button %0d held ticks got %0d want %0d", e.button, h, e.held));
      end
      if (last !== e.last) begin
        report($sformatf("button %0d last flag got %0b want %0b", e.button, last, e.last));
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [23:0]                    in_tdata = '0;    // buttons_down[7:0], frame_ticks[23:8]
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [31:0]                    out_tdata;        // button_index[2:0], held_ticks[26:3]
  logic [1:0]                     out_tuser;        // event_kind[1:0]
  logic                           out_tlast;
  logic                           cfg_we = 1'b0;
  logic [bphd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bphd_pkg::CFG_W-1:0]     cfg_wdata = '0;

  press_tracker tracker;
  bit           burst = 1'b0;
  int           sent = 0;
  int           settings = 0;

  button_press_hold_double_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_frame(input logic [bphd_pkg::BUTTONS_W-1:0] down,
                            input logic [bphd_pkg::FRAME_W-1:0] ticks);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ticks, down};
    do @(posedge clk); while (!in_tready);
    tracker.note_frame(down, ticks);
    sent++;
    if ($urandom_range(0, 31) == 0) begin
      burst = !burst;
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [bphd_pkg::CFG_W-1:0] lt,
                           input logic [bphd_pkg::CFG_W-1:0] win);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= bphd_pkg::REG_LIFETIME;
    cfg_wdata <= lt;
    @(posedge clk);
    cfg_index <= bphd_pkg::REG_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(bphd_pkg::REG_LIFETIME, lt);
    tracker.set_reg(bphd_pkg::REG_WINDOW, win);
    settings++;
  endtask

  function automatic logic [bphd_pkg::BUTTONS_W-1:0] side_noise(
      bit noisy, logic [bphd_pkg::BUTTONS_W-1:0] mask);
    return noisy ? (bphd_pkg::BUTTONS_W'($urandom) & mask) : '0;
  endfunction

  // press, hold, release, quiet gap, press again on one button
  task automatic press_sequence(input int max_dt);
    int                             b;
    logic [bphd_pkg::BUTTONS_W-1:0] own;
    logic [bphd_pkg::BUTTONS_W-1:0] lower;
    bit                             noisy;
    b = $urandom_range(0, bphd_pkg::BUTTONS_W-1);
    own = bphd_pkg::BUTTONS_W'(1) << b;
    lower = own - bphd_pkg::BUTTONS_W'(1);
    noisy = ($urandom_range(0, 2) == 0);
    send_frame(own | side_noise(noisy, lower), $urandom_range(0, max_dt));
    repeat ($urandom_range(0, 2))
      send_frame(own | side_noise(noisy, lower), $urandom_range(0, max_dt));
    send_frame(side_noise(noisy, lower), $urandom_range(0, max_dt));
    repeat ($urandom_range(0, 2))
      send_frame(side_noise(noisy, lower), $urandom_range(0, max_dt));
    send_frame(own | side_noise(noisy, lower), $urandom_range(0, max_dt));
  endtask

  task automatic random_phase(input logic [bphd_pkg::CFG_W-1:0] lt,
                              input logic [bphd_pkg::CFG_W-1:0] win,
                              input int max_dt, input int n_frames);
    int first;
    configure(lt, win);
    first = sent;
    while (sent - first < n_frames) begin
      if ($urandom_range(0, 3) != 0) begin
        press_sequence(max_dt);
      end else begin
        send_frame(bphd_pkg::BUTTONS_W'($urandom), $urandom_range(0, max_dt));
      end
    end
  endtask

  initial begin
    int busy_frames;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: all buttons at once, extremes of frame ticks
    send_frame(8'h00, 16'd0);
    send_frame(8'hFF, 16'hFFFF);
    send_frame(8'hFF, 16'd0);
    send_frame(8'h00, 16'hFFFF);
    send_frame(8'hFF, 16'd1);
    send_frame(8'h55, 16'd12345);
    send_frame(8'hAA, 16'd0);
    send_frame(8'h00, 16'd0);
    send_frame(8'h00, 16'd0);

    // buffer count reaching exactly zero survives, one tick more expires
    configure(24'd1000, 24'hFFFFFF);
    send_frame(8'h04, 16'd7);
    send_frame(8'h00, 16'd3);
    send_frame(8'h00, 16'd1000);
    send_frame(8'h04, 16'd0);
    send_frame(8'h00, 16'd2);
    send_frame(8'h00, 16'd1001);
    send_frame(8'h04, 16'd5);

    // window edge: strictly below passes
    configure(24'hFFFFFF, 24'd1000);
    send_frame(8'h10, 16'd9);
    send_frame(8'h00, 16'd9);
    send_frame(8'h00, 16'd999);
    send_frame(8'h10, 16'd0);
    send_frame(8'h00, 16'd1);
    send_frame(8'h00, 16'd1000);
    send_frame(8'h10, 16'd0);
    send_frame(8'h00, 16'd1);

    // lifetime shrunk below the remaining count, elapsed goes negative
    configure(24'd100, 24'd0);
    send_frame(8'h10, 16'd3);

    random_phase(bphd_pkg::LIFETIME_RESET, bphd_pkg::WINDOW_RESET, 65535, 45);
    random_phase(24'd1, 24'd0, 2, 45);
    random_phase(24'd3000, 24'd1000, 1500, 45);
    random_phase(bphd_pkg::CFG_W'($urandom_range(1, 24'hFFFFFF)),
                 bphd_pkg::CFG_W'($urandom), 65535, 45);

    // long hold of the top button to push held time into saturation
    configure(24'hFFFFFF, 24'hFFFFFF);
    busy_frames = 276;
    repeat (busy_frames) send_frame(8'h80 | bphd_pkg::BUTTONS_W'($urandom & 32'h7F),
                                    $urandom_range(62000, 65535));
    send_frame(8'h00, 16'hFFFF);
    send_frame(8'h80, 16'hFFFF);

    settle();
    if (tracker.pending.size() != 0) begin
      tracker.report($sformatf("%0d expected events never arrived", tracker.pending.size()));
    end
    $display("covered %0d frames, %0d events, %0d double presses, %0d saturated held times",
             tracker.frames, tracker.events, tracker.doubles, tracker.saturated);
    $display("over %0d register settings, %0d mismatches", settings + 1, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_event(out_tdata[2:0], out_tuser, out_tdata[26:3], out_tlast);
    end
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
sv/bphd_pkg.sv
sv/bphd_lane.sv
sv/bphd_merge.sv
sv/button_press_hold_double_detector.sv
sim/tb_button_press_hold_double_detector.sv
